>>> design/ioseg_pkg.sv
// Package for the I/O sequential segment histogram.
// Field widths, mode and pipeline operation codes, and the stage structure.
// No dependencies.
`default_nettype none
package ioseg_pkg;

    localparam int NUM_BINS_DEF      = 512;
    localparam int COUNTER_WIDTH_DEF = 40;

    localparam int MODE_W = 2;
    localparam int PID_W  = 32;
    localparam int LBA_W  = 48;
    localparam int LEN_W  = 10;
    localparam int BIX_W  = 9;
    localparam int OUT_W  = 40;

    localparam logic [LEN_W-1:0] MERGE_LIMIT_RST = 10'd512;
    localparam logic [LEN_W-1:0] LEN_MAX         = 10'd1023;

    typedef enum logic [MODE_W-1:0] {
        MODE_REQUEST    = 2'd0,
        MODE_FLUSH      = 2'd1,
        MODE_READ_BIN   = 2'd2,
        MODE_READ_TOTAL = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INC  = 2'd1,
        OP_READ = 2'd2
    } t_op;

    // Closure fields carried with a word through the histogram stage
    typedef struct packed {
        logic             closed;
        logic [LEN_W-1:0] length;
        logic             is_write;
        logic [LEN_W-1:0] requests;
    } t_close;

endpackage
`default_nettype wire

>>> design/ioseg_req_if.sv
// Request channel: valid/ready handshake with the request record payload.
// Depends on ioseg_pkg.
`default_nettype none
interface ioseg_req_if;
    logic                            valid;
    logic                            ready;
    logic [ioseg_pkg::MODE_W-1:0]    mode;
    logic [ioseg_pkg::PID_W-1:0]     process_id;
    logic [ioseg_pkg::LBA_W-1:0]     block_address;
    logic [ioseg_pkg::LEN_W-1:0]     block_count;
    logic                            is_write;
    logic [ioseg_pkg::BIX_W-1:0]     bin_index;

    modport source (output valid, mode, process_id, block_address, block_count,
                    is_write, bin_index, input ready);
    modport sink   (input valid, mode, process_id, block_address, block_count,
                    is_write, bin_index, output ready);
endinterface
`default_nettype wire

>>> design/ioseg_res_if.sv
// Result channel: valid/ready handshake with the segment and count payload.
// Depends on ioseg_pkg.
`default_nettype none
interface ioseg_res_if;
    logic                          valid;
    logic                          ready;
    logic                          segment_closed;
    logic [ioseg_pkg::LEN_W-1:0]   closed_length;
    logic                          closed_is_write;
    logic [ioseg_pkg::LEN_W-1:0]   closed_requests;
    logic [ioseg_pkg::OUT_W-1:0]   count_value;

    modport source (output valid, segment_closed, closed_length, closed_is_write,
                    closed_requests, count_value, input ready);
    modport sink   (input valid, segment_closed, closed_length, closed_is_write,
                    closed_requests, count_value, output ready);
endinterface
`default_nettype wire

>>> design/io_sequential_segment_histogram.sv
// Top level of the I/O sequential segment histogram.
// Depends on ioseg_pkg, ioseg_req_if, ioseg_res_if and ioseg_ram.
//
// Usage:
//   i_req carries one request word per handshake (valid and ready high at a
//   rising edge): a request record, a flush, a histogram bin read or a total
//   read, chosen by mode. o_res returns exactly one result word per request
//   word, in order. i_cfg_we/i_cfg_wdata write merge_limit; write it only
//   while the block is idle.
//   Throughput: one word per cycle while o_res.ready is high and no clearing
//   pass runs, set by the single read-modify-write pass through the histogram
//   RAM (one read port, one write port; a one-entry write-back register
//   forwards to the following read). Each word passes the histogram read
//   stage, then the output register.
//   Reset: synchronous, active low. Afterwards the histogram RAM is cleared
//   one entry per cycle, all 2*2^ceil(log2(NUM_BINS)) entries (1024 at default);
//   i_req.ready stays low during that pass, configuration writes are taken.
//   Stall: while o_res.ready is low the result holds in the output register,
//   one more word is taken into the read stage, then ready drops.
`default_nettype none
module io_sequential_segment_histogram #(
    parameter int NUM_BINS      = ioseg_pkg::NUM_BINS_DEF,
    parameter int COUNTER_WIDTH = ioseg_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    ioseg_req_if.sink                        i_req,
    ioseg_res_if.source                      o_res,
    input  wire logic                        i_cfg_we,
    input  wire logic [ioseg_pkg::LEN_W-1:0] i_cfg_wdata
);

    localparam int LEN_W  = ioseg_pkg::LEN_W;
    localparam int LBA_W  = ioseg_pkg::LBA_W;
    localparam int PID_W  = ioseg_pkg::PID_W;
    localparam int OUT_W  = ioseg_pkg::OUT_W;
    localparam int CNT_W  = COUNTER_WIDTH;
    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int MEM_AW = BIN_W + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;
    localparam int CMP_W  = ((BIN_W > LEN_W) ? BIN_W : LEN_W) + 1;
    localparam logic [CMP_W-1:0]  BIN_LAST = CMP_W'(NUM_BINS - 1);
    localparam logic [CMP_W-1:0]  BIN_CNT  = CMP_W'(NUM_BINS);
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [MEM_AW-1:0] CLR_LAST = {MEM_AW{1'b1}};

    // Configuration
    logic [LEN_W-1:0] r_merge_limit;

    // Open segment
    logic             r_seg_open, n_seg_open;
    logic [PID_W-1:0] r_seg_pid, n_seg_pid;
    logic [LBA_W-1:0] r_seg_start, n_seg_start;
    logic [LEN_W-1:0] r_seg_len, n_seg_len;
    logic             r_seg_wr, n_seg_wr;
    logic [LEN_W-1:0] r_seg_req, n_seg_req;

    logic [CNT_W-1:0] r_rd_total, n_rd_total;
    logic [CNT_W-1:0] r_wr_total, n_wr_total;

    // Clearing pass
    logic              r_clearing;
    logic [MEM_AW-1:0] r_clr_addr;

    // Histogram stage
    logic               r_s1_valid;
    ioseg_pkg::t_op     r_s1_op, n_s1_op;
    logic [MEM_AW-1:0]  r_s1_addr, n_s1_addr;
    ioseg_pkg::t_close  r_s1_close, n_s1_close;
    logic [CNT_W-1:0]   r_s1_count, n_s1_count;

    // Write-back forwarding
    logic              r_wb_valid;
    logic [MEM_AW-1:0] r_wb_addr;
    logic [CNT_W-1:0]  r_wb_data;

    // Output register
    logic              r_out_valid;
    ioseg_pkg::t_close r_out_close;
    logic [CNT_W-1:0]  r_out_count;

    logic              w_adv, w_acc;
    logic              w_joins, w_close;
    logic [LEN_W:0]    w_len_sum;
    logic [LEN_W-1:0]  w_len_m1;
    logic [CMP_W-1:0]  w_bin_ext;
    logic [CMP_W-1:0]  w_bix_ext;
    logic [BIN_W-1:0]  w_close_bin;
    logic [CNT_W:0]    w_total_sum;
    logic [CNT_W-1:0]  w_total_sel;
    logic [CNT_W-1:0]  w_rdata, w_hist;
    logic [CNT_W-1:0]  w_hist_inc;
    logic              w_mem_we;
    logic [MEM_AW-1:0] w_mem_waddr;
    logic [CNT_W-1:0]  w_mem_wdata;
    logic              w_mem_re;
    ioseg_pkg::t_mode  w_mode;

    assign w_mode = ioseg_pkg::t_mode'(i_req.mode);
    assign w_adv  = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_clearing && (!r_s1_valid || w_adv);
    assign w_acc  = i_req.valid && i_req.ready;

    // Segment merge and closure decision
    assign w_joins = r_seg_open
                  && (r_seg_len < r_merge_limit)
                  && (r_seg_pid == i_req.process_id)
                  && ((r_seg_start + LBA_W'(r_seg_len)) == i_req.block_address)
                  && (r_seg_wr == i_req.is_write);
    assign w_len_sum = {1'b0, r_seg_len} + {1'b0, i_req.block_count};

    assign w_len_m1    = (r_seg_len == '0) ? '0 : r_seg_len - LEN_W'(1);
    assign w_bin_ext   = CMP_W'(w_len_m1);
    assign w_close_bin = (w_bin_ext > BIN_LAST) ? BIN_LAST[BIN_W-1:0] : w_bin_ext[BIN_W-1:0];
    assign w_bix_ext   = CMP_W'(i_req.bin_index);

    assign w_total_sel = r_seg_wr ? r_wr_total : r_rd_total;
    assign w_total_sum = {1'b0, w_total_sel} + (CNT_W + 1)'(r_seg_req);

    always_comb begin
        w_close     = 1'b0;
        n_seg_open  = r_seg_open;
        n_seg_pid   = r_seg_pid;
        n_seg_start = r_seg_start;
        n_seg_len   = r_seg_len;
        n_seg_wr    = r_seg_wr;
        n_seg_req   = r_seg_req;
        n_s1_op     = ioseg_pkg::OP_NONE;
        n_s1_addr   = {r_seg_wr, w_close_bin};
        n_s1_count  = '0;
        case (w_mode)
            ioseg_pkg::MODE_REQUEST: begin
                if (w_joins) begin
                    n_seg_len = w_len_sum[LEN_W] ? ioseg_pkg::LEN_MAX : w_len_sum[LEN_W-1:0];
                    if (r_seg_req < ioseg_pkg::LEN_MAX) begin
                        n_seg_req = r_seg_req + LEN_W'(1);
                    end
                end else begin
                    w_close     = r_seg_open;
                    n_seg_open  = 1'b1;
                    n_seg_pid   = i_req.process_id;
                    n_seg_start = i_req.block_address;
                    n_seg_len   = i_req.block_count;
                    n_seg_wr    = i_req.is_write;
                    n_seg_req   = LEN_W'(1);
                end
            end
            ioseg_pkg::MODE_FLUSH: begin
                w_close    = r_seg_open;
                n_seg_open = 1'b0;
            end
            ioseg_pkg::MODE_READ_BIN: begin
                n_s1_addr = {i_req.is_write, w_bix_ext[BIN_W-1:0]};
                if (w_bix_ext < BIN_CNT) begin
                    n_s1_op = ioseg_pkg::OP_READ;
                end
            end
            ioseg_pkg::MODE_READ_TOTAL: begin
                n_s1_count = i_req.is_write ? r_wr_total : r_rd_total;
            end
            default: begin
                n_s1_op = ioseg_pkg::OP_NONE;
            end
        endcase
        if (w_close) begin
            n_s1_op = ioseg_pkg::OP_INC;
        end
        n_s1_close.closed   = w_close;
        n_s1_close.length   = w_close ? r_seg_len : '0;
        n_s1_close.is_write = w_close ? r_seg_wr : 1'b0;
        n_s1_close.requests = w_close ? r_seg_req : '0;
    end

    always_comb begin
        n_rd_total = r_rd_total;
        n_wr_total = r_wr_total;
        if (w_acc && w_close) begin
            if (r_seg_wr) begin
                n_wr_total = w_total_sum[CNT_W] ? CNT_MAX : w_total_sum[CNT_W-1:0];
            end else begin
                n_rd_total = w_total_sum[CNT_W] ? CNT_MAX : w_total_sum[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_limit <= ioseg_pkg::MERGE_LIMIT_RST;
            r_seg_open    <= 1'b0;
            r_seg_pid     <= '0;
            r_seg_start   <= '0;
            r_seg_len     <= '0;
            r_seg_wr      <= 1'b0;
            r_seg_req     <= '0;
            r_rd_total    <= '0;
            r_wr_total    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_merge_limit <= i_cfg_wdata;
            end
            if (w_acc) begin
                r_seg_open  <= n_seg_open;
                r_seg_pid   <= n_seg_pid;
                r_seg_start <= n_seg_start;
                r_seg_len   <= n_seg_len;
                r_seg_wr    <= n_seg_wr;
                r_seg_req   <= n_seg_req;
            end
            r_rd_total <= n_rd_total;
            r_wr_total <= n_wr_total;
        end
    end

    // Histogram read-modify-write
    assign w_hist     = (r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : w_rdata;
    assign w_hist_inc = (w_hist == CNT_MAX) ? CNT_MAX : w_hist + CNT_W'(1);

    assign w_mem_re    = w_acc && (n_s1_op != ioseg_pkg::OP_NONE);
    assign w_mem_we    = r_clearing
                      || (r_s1_valid && w_adv && (r_s1_op == ioseg_pkg::OP_INC));
    assign w_mem_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign w_mem_wdata = r_clearing ? '0 : w_hist_inc;

    ioseg_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MEM_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (n_s1_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + MEM_AW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
                r_wb_valid <= 1'b0;
            end else if (w_mem_we) begin
                r_wb_valid <= 1'b1;
            end
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_op    <= n_s1_op;
            r_s1_addr  <= n_s1_addr;
            r_s1_close <= n_s1_close;
            r_s1_count <= n_s1_count;
        end
        if (w_mem_we && !r_clearing) begin
            r_wb_addr <= r_s1_addr;
            r_wb_data <= w_hist_inc;
        end
        if (w_adv && r_s1_valid) begin
            r_out_close <= r_s1_close;
            case (r_s1_op)
                ioseg_pkg::OP_READ: r_out_count <= w_hist;
                ioseg_pkg::OP_INC:  r_out_count <= '0;
                default:            r_out_count <= r_s1_count;
            endcase
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.segment_closed  = r_out_close.closed;
    assign o_res.closed_length   = r_out_close.length;
    assign o_res.closed_is_write = r_out_close.is_write;
    assign o_res.closed_requests = r_out_close.requests;
    assign o_res.count_value     = OUT_W'(r_out_count);

    // Assertions
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !w_acc)
        else $error("word accepted during histogram clear");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_addr) && $stable(w_rdata)))
        else $error("histogram stage lost its word while stalled");

    a_close_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.segment_closed) |-> (o_res.count_value == '0))
        else $error("closing word carries a count");

    a_open_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.segment_closed)
            |-> (o_res.closed_length == '0 && o_res.closed_requests == '0))
        else $error("closure fields set without a closure");

endmodule
`default_nettype wire

>>> design/ioseg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module ioseg_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> sim/tb_io_sequential_segment_histogram.sv
// Self-checking testbench for io_sequential_segment_histogram: directed table, then random
// request streams over several merge limits, checked against a local segment/histogram model.
// Depends on ioseg_pkg, ioseg_req_if, ioseg_res_if and the design under test.
`default_nettype none
module tb_io_sequential_segment_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    import ioseg_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int NB           = NUM_BINS_DEF;
    localparam int CW           = COUNTER_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef struct packed {
        t_mode            mode;
        logic [PID_W-1:0] pid;
        logic [LBA_W-1:0] lba;
        logic [LEN_W-1:0] nblk;
        logic             wr;
        logic [BIX_W-1:0] bix;
    } t_word;

    typedef struct packed {
        t_close           seg;
        logic [OUT_W-1:0] count;
    } t_report;

    typedef struct packed {
        t_word   w;
        bit      typed;
        t_report want;
    } t_row;

    localparam t_report NO_REPORT = '0;
    localparam bit      TYPED     = 1'b1;
    localparam bit      PREDICT   = 1'b0;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_wdata;

    ioseg_req_if req_ch();
    ioseg_res_if res_ch();

    io_sequential_segment_histogram u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Model state
    logic [LEN_W-1:0] merge_lim;
    logic             run_open;
    logic [PID_W-1:0] run_pid;
    logic [LBA_W-1:0] run_lba;
    logic [LEN_W-1:0] run_len;
    logic             run_wr;
    logic [LEN_W-1:0] run_reqs;
    logic [CW-1:0]    len_hist [2][NB];
    logic [CW-1:0]    rd_total;
    logic [CW-1:0]    wr_total;

    t_report report_q [$];
    int      errors = 0;

    // Random stream state
    logic [PID_W-1:0] str_pid = '0;
    logic [LBA_W-1:0] str_lba = '0;
    logic             str_wr  = 1'b0;

    int gap_pct   = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;

    t_row directed_plan [0:24] = '{
        '{'{MODE_READ_TOTAL, 32'd0, 48'd0, 10'd1, 1'b0, 9'd0}, TYPED, NO_REPORT},
        '{'{MODE_READ_TOTAL, 32'd0, 48'd0, 10'd1, 1'b1, 9'd0}, TYPED, NO_REPORT},
        '{'{MODE_READ_BIN, 32'd0, 48'd0, 10'd1, 1'b0, 9'd0}, TYPED, NO_REPORT},
        '{'{MODE_READ_BIN, 32'd0, 48'd0, 10'd1, 1'b1, 9'd511}, TYPED, NO_REPORT},
        '{'{MODE_FLUSH, 32'd0, 48'd0, 10'd1, 1'b0, 9'd0}, TYPED, NO_REPORT},
        '{'{MODE_REQUEST, 32'd0, 48'd0, 10'd1, 1'b0, 9'd0}, TYPED, NO_REPORT},
        '{'{MODE_REQUEST, 32'd0, 48'd1, 10'd512, 1'b0, 9'd0}, TYPED, NO_REPORT},
        '{'{MODE_REQUEST, 32'd0, 48'd513, 10'd510, 1'b0, 9'd0}, TYPED,
          '{'{1'b1, 10'd513, 1'b0, 10'd2}, 40'd0}},
        '{'{MODE_REQUEST, 32'd0, 48'd1023, 10'd1, 1'b1, 9'd0}, PREDICT, NO_REPORT},
        '{'{MODE_REQUEST, 32'hFFFF_FFFF, 48'd1024, 10'd1, 1'b1, 9'd0}, PREDICT, NO_REPORT},
        '{'{MODE_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 10'd1, 1'b1, 9'd0},
          PREDICT, NO_REPORT},
        '{'{MODE_REQUEST, 32'hFFFF_FFFF, 48'd0, 10'd510, 1'b1, 9'd0}, PREDICT, NO_REPORT},
        '{'{MODE_REQUEST, 32'hFFFF_FFFF, 48'd510, 10'd512, 1'b1, 9'd0}, PREDICT, NO_REPORT},
        '{'{MODE_READ_BIN, 32'd7, 48'd5, 10'd3, 1'b1, 9'd0}, PREDICT, NO_REPORT},
        '{'{MODE_FLUSH, 32'd0, 48'd0, 10'd1, 1'b0, 9'd0}, TYPED,
          '{'{1'b1, 10'd1023, 1'b1, 10'd3}, 40'd0}},
        '{'{MODE_FLUSH, 32'd0, 48'd0, 10'd1, 1'b1, 9'd0}, TYPED, NO_REPORT},
        '{'{MODE_READ_BIN, 32'd0, 48'd0, 10'd1, 1'b1, 9'd511}, PREDICT, NO_REPORT},
        '{'{MODE_READ_BIN, 32'd0, 48'd0, 10'd1, 1'b0, 9'd509}, PREDICT, NO_REPORT},
        '{'{MODE_READ_TOTAL, 32'd0, 48'd0, 10'd1, 1'b0, 9'd0}, PREDICT, NO_REPORT},
        '{'{MODE_READ_TOTAL, 32'd0, 48'd0, 10'd1, 1'b1, 9'd0}, PREDICT, NO_REPORT},
        '{'{MODE_REQUEST, 32'h5A5A_A5A5, 48'hAAAA_5555_0000, 10'h155, 1'b0, 9'd0},
          PREDICT, NO_REPORT},
        '{'{MODE_READ_TOTAL, 32'd0, 48'd0, 10'd1, 1'b0, 9'd0}, PREDICT, NO_REPORT},
        '{'{MODE_REQUEST, 32'h5A5A_A5A5, 48'hAAAA_5555_0155, 10'h2AA, 1'b0, 9'd0},
          PREDICT, NO_REPORT},
        '{'{MODE_FLUSH, 32'd0, 48'd0, 10'd1, 1'b0, 9'd0}, PREDICT, NO_REPORT},
        '{'{MODE_READ_BIN, 32'd0, 48'd0, 10'd1, 1'b0, 9'd511}, PREDICT, NO_REPORT}
    };

    function automatic logic [CW-1:0] sat_add(logic [CW-1:0] a, logic [LEN_W-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + (CW + 1)'(b);
        return s[CW] ? '1 : s[CW-1:0];
    endfunction

    // Counts the open segment into its bin and request total
    function automatic t_close retire_run();
        int     bin;
        t_close c;
        bin = (run_len == '0) ? 0 : int'(run_len) - 1;
        if (bin > NB - 1) bin = NB - 1;
        len_hist[run_wr][bin] = sat_add(len_hist[run_wr][bin], LEN_W'(1));
        if (run_wr) wr_total = sat_add(wr_total, run_reqs);
        else        rd_total = sat_add(rd_total, run_reqs);
        c.closed   = 1'b1;
        c.length   = run_len;
        c.is_write = run_wr;
        c.requests = run_reqs;
        run_open   = 1'b0;
        return c;
    endfunction

    function automatic t_report profile_word(t_word w);
        t_report          r;
        logic [LBA_W-1:0] run_end;
        logic [LEN_W:0]   grown;
        logic             joins;
        r = NO_REPORT;
        case (w.mode)
            MODE_REQUEST: begin
                run_end = run_lba + LBA_W'(run_len);
                joins = run_open && (run_len < merge_lim) && (run_pid == w.pid)
                        && (run_end == w.lba) && (run_wr == w.wr);
                if (joins) begin
                    grown = {1'b0, run_len} + {1'b0, w.nblk};
                    run_len = grown[LEN_W] ? LEN_MAX : grown[LEN_W-1:0];
                    if (run_reqs != LEN_MAX) run_reqs = run_reqs + 1'b1;
                end else begin
                    if (run_open) r.seg = retire_run();
                    run_open = 1'b1;
                    run_pid  = w.pid;
                    run_lba  = w.lba;
                    run_len  = w.nblk;
                    run_wr   = w.wr;
                    run_reqs = LEN_W'(1);
                end
            end
            MODE_FLUSH: begin
                if (run_open) r.seg = retire_run();
            end
            MODE_READ_BIN: begin
                if (int'(w.bix) < NB) r.count = OUT_W'(len_hist[w.wr][w.bix]);
            end
            default: begin
                r.count = OUT_W'(w.wr ? wr_total : rd_total);
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got_v, logic [63:0] exp_v);
        $display("ERROR %0t ns: %s: got %0h, expected %0h", $realtime, what, got_v, exp_v);
        errors++;
    endtask

    task automatic check_report(t_report got, t_report exp);
        if (got.seg.closed !== exp.seg.closed)
            flag_mismatch("segment_closed", 64'(got.seg.closed), 64'(exp.seg.closed));
        if (got.seg.length !== exp.seg.length)
            flag_mismatch("closed_length", 64'(got.seg.length), 64'(exp.seg.length));
        if (got.seg.is_write !== exp.seg.is_write)
            flag_mismatch("closed_is_write", 64'(got.seg.is_write), 64'(exp.seg.is_write));
        if (got.seg.requests !== exp.seg.requests)
            flag_mismatch("closed_requests", 64'(got.seg.requests), 64'(exp.seg.requests));
        if (got.count !== exp.count)
            flag_mismatch("count_value", 64'(got.count), 64'(exp.count));
    endtask

    // Result side: checks each accepted word, then decides ready for the next edge
    always @(posedge i_clk) begin : res_side
        t_report got;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got.seg.closed   = res_ch.segment_closed;
            got.seg.length   = res_ch.closed_length;
            got.seg.is_write = res_ch.closed_is_write;
            got.seg.requests = res_ch.closed_requests;
            got.count        = res_ch.count_value;
            if (report_q.size() == 0) flag_mismatch("word with nothing expected", 64'(got), 0);
            else                      check_report(got, report_q.pop_front());
        end
        if (!hold_req) hold_taken = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic offer_word(t_word w, bit typed, t_report want);
        t_report pred;
        while ($urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= w.mode;
        req_ch.process_id    <= w.pid;
        req_ch.block_address <= w.lba;
        req_ch.block_count   <= w.nblk;
        req_ch.is_write      <= w.wr;
        req_ch.bin_index     <= w.bix;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pred = profile_word(w);
        report_q.push_back(typed ? want : pred);
    endtask

    // Mostly contiguous request streams, with new streams, broken continuations, flushes and reads
    task automatic draw_word(output t_word w);
        int pick;
        int size_pick;
        w      = '0;
        w.pid  = $urandom;
        w.lba  = {16'($urandom), 32'($urandom)};
        w.wr   = 1'($urandom_range(1));
        w.bix  = BIX_W'($urandom_range(511));
        size_pick = $urandom_range(99);
        if (size_pick < 60)      w.nblk = LEN_W'($urandom_range(8, 1));
        else if (size_pick < 85) w.nblk = LEN_W'($urandom_range(64, 1));
        else                     w.nblk = LEN_W'($urandom_range(512, 1));
        pick = $urandom_range(99);
        if (pick < 76) begin
            w.mode = MODE_REQUEST;
            if (pick >= 68) begin
                case ($urandom_range(3))
                    0: str_pid = '0;
                    1: str_pid = '1;
                    2: str_pid = PID_W'($urandom_range(3));
                    default: str_pid = $urandom;
                endcase
                case ($urandom_range(2))
                    0: str_lba = w.lba;
                    1: str_lba = '1 - LBA_W'($urandom_range(600));
                    default: str_lba = LBA_W'($urandom_range(4095));
                endcase
                str_wr = 1'($urandom_range(1));
            end
            w.pid   = str_pid;
            w.lba   = str_lba;
            w.wr    = str_wr;
            str_lba = str_lba + LBA_W'(w.nblk);
        end else if (pick < 82) begin
            w.mode = MODE_REQUEST;
            w.pid  = str_pid;
            w.lba  = str_lba;
            w.wr   = str_wr;
            case ($urandom_range(2))
                0: w.pid = str_pid ^ (PID_W'(1) << $urandom_range(31));
                1: w.lba = str_lba + ($urandom_range(1) ? LBA_W'(1) : '1);
                default: w.wr = ~str_wr;
            endcase
        end else if (pick < 87) begin
            w.mode = MODE_FLUSH;
        end else if (pick < 94) begin
            w.mode = MODE_READ_BIN;
            if ($urandom_range(1)) w.bix = BIX_W'($urandom_range(31));
        end else begin
            w.mode = MODE_READ_TOTAL;
        end
    endtask

    task automatic settle();
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_merge_limit(logic [LEN_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        merge_lim = value;
    endtask

    task automatic run_phase(logic [LEN_W-1:0] limit, int gap, int stall, int n_words,
                             bit hold);
        t_word w;
        write_merge_limit(limit);
        gap_pct   = gap;
        stall_pct = stall;
        hold_req <= hold;
        repeat (n_words) begin
            draw_word(w);
            offer_word(w, PREDICT, NO_REPORT);
        end
        req_ch.valid <= 1'b0;
        settle();
        hold_req <= 1'b0;
    endtask

    initial begin
        int k;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        req_ch.valid         = 1'b0;
        req_ch.mode          = '0;
        req_ch.process_id    = '0;
        req_ch.block_address = '0;
        req_ch.block_count   = '0;
        req_ch.is_write      = 1'b0;
        req_ch.bin_index     = '0;
        res_ch.ready         = 1'b0;

        merge_lim = MERGE_LIMIT_RST;
        run_open  = 1'b0;
        run_pid   = '0;
        run_lba   = '0;
        run_len   = '0;
        run_wr    = 1'b0;
        run_reqs  = '0;
        rd_total  = '0;
        wr_total  = '0;
        foreach (len_hist[d, b]) len_hist[d][b] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < $size(directed_plan); k++)
            offer_word(directed_plan[k].w, directed_plan[k].typed, directed_plan[k].want);
        req_ch.valid <= 1'b0;
        settle();

        run_phase(10'd1023, 0, 0, 320, 1'b1);
        run_phase(10'd0, 50, 0, 250, 1'b0);
        run_phase(10'd1, 0, 50, 250, 1'b0);
        run_phase(10'd512, 10, 10, 250, 1'b0);
        run_phase(LEN_W'($urandom_range(511, 2)), 0, 0, 230, 1'b0);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
